// ===== rtl/core/postfix_expression_evaluator_macros.svh =====
// Assertion macros used by the evaluator's control module.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define PEE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define PEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pee_pkg.sv =====
package pee_pkg;

   // Character codes of the expression alphabet.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_TIMES = 8'h2A;
   localparam logic [7:0] CHAR_DIV   = 8'h2F;
   localparam logic [7:0] CHAR_POW   = 8'h5E;

   // Status codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_UNDER   = 3'd1;
   localparam logic [2:0] ST_DIVZERO = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [2:0]         status;
   } rsp_type;

   // Datapath operation selected by the controller.
   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_POW
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       rd_top;     // read the top two entries
      logic       push_digit; // write a digit above the top
      logic [3:0] digit;
      logic       start;      // start an operation on the read operands
      op_type     op;
      logic       write_res;  // write the result, pop one
      logic       finish;     // build the response, clear the stack
      logic [2:0] err;        // error to record (ST_OK for none)
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;
      logic done;
      logic rhs_zero;
      logic few;   // fewer than two operands
      logic empty;
      logic full;
   } sts_type;

endpackage

// ===== rtl/core/pee_datapath.sv =====
module pee_datapath #(
   parameter int STACK_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  pee_pkg::cmd_type  cmd,
   output pee_pkg::sts_type  sts,
   output pee_pkg::rsp_type  rsp_data
);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [31:0] mem [STACK_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [2:0] err_ff, err_in;
   logic [31:0] rhs_ff, lhs_ff;
   logic [31:0] res_ff, res_in;
   logic [31:0] acc_ff, acc_in;     // quotient / power accumulator
   logic [31:0] base_ff, base_in;   // remainder / power base
   logic [31:0] ex_ff, ex_in;       // dividend shift / exponent
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   pee_pkg::op_type op_ff, op_in;
   pee_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] top_idx, sec_idx;
   logic [32:0] trial;
   logic [31:0] lmag, rmag, mres;

   assign top_idx = count_ff - CW'(1);
   assign sec_idx = count_ff - CW'(2);
   assign lmag = lhs_ff[31] ? (32'd0 - lhs_ff) : lhs_ff;
   assign rmag = rhs_ff[31] ? (32'd0 - rhs_ff) : rhs_ff;
   assign trial = {base_ff, ex_ff[31]} - {1'b0, dvs_ff};
   assign mres = (step_ff[0] ? base_ff : acc_ff) * base_ff;

   // Stack memory: one write port, reads of the two top entries.
   always_ff @(posedge clock) begin
      if (cmd.push_digit && count_ff < CW'(STACK_DEPTH)) begin
         mem[count_ff[AW-1:0]] <= {28'd0, cmd.digit};
      end else if (cmd.write_res) begin
         mem[sec_idx[AW-1:0]] <= res_ff;
      end
      if (cmd.rd_top) begin
         rhs_ff <= mem[top_idx[AW-1:0]];
         lhs_ff <= mem[sec_idx[AW-1:0]];
      end
   end

   // Add, subtract and multiply results, iterative divider and square-and-multiply power unit.
   always_comb begin
      busy_in = busy_ff; done_in = 1'b0; step_in = step_ff; op_in = op_ff;
      acc_in = acc_ff; base_in = base_ff; ex_in = ex_ff; dvs_in = dvs_ff;
      res_in = res_ff; neg_in = neg_ff;
      if (cmd.start) begin
         op_in = cmd.op;
         step_in = '0;
         neg_in = lhs_ff[31] ^ rhs_ff[31];
         case (cmd.op)
            pee_pkg::OP_ADD: begin res_in = lhs_ff + rhs_ff; done_in = 1'b1; end
            pee_pkg::OP_SUB: begin res_in = lhs_ff - rhs_ff; done_in = 1'b1; end
            pee_pkg::OP_MUL: begin res_in = lhs_ff * rhs_ff; done_in = 1'b1; end
            pee_pkg::OP_DIV: begin
               busy_in = 1'b1; acc_in = '0; base_in = '0; ex_in = lmag; dvs_in = rmag;
            end
            default: begin
               if (rhs_ff[31]) begin
                  done_in = 1'b1;
                  if (lhs_ff == 32'd1) res_in = 32'd1;
                  else if (lhs_ff == 32'hFFFF_FFFF) res_in = rhs_ff[0] ? lhs_ff : 32'd1;
                  else res_in = '0;
               end else begin
                  busy_in = 1'b1; acc_in = 32'd1; base_in = lhs_ff; ex_in = rhs_ff;
               end
            end
         endcase
      end else if (busy_ff) begin
         step_in = step_ff + 6'd1;
         if (op_ff == pee_pkg::OP_DIV) begin
            // One restoring division step per cycle.
            ex_in = {ex_ff[30:0], 1'b0};
            if (!trial[32]) begin
               base_in = trial[31:0]; acc_in = {acc_ff[30:0], 1'b1};
            end else begin
               base_in = {base_ff[30:0], ex_ff[31]}; acc_in = {acc_ff[30:0], 1'b0};
            end
            if (step_ff == 6'd31) begin
               busy_in = 1'b0; done_in = 1'b1;
               res_in = neg_ff ? (32'd0 - acc_in) : acc_in;
            end
         end else begin
            // Power alternates a multiply step and a square step per exponent bit.
            if (!step_ff[0]) begin
               if (ex_ff[0]) acc_in = mres;
            end else begin
               base_in = mres; ex_in = {1'b0, ex_ff[31:1]};
            end
            if (ex_ff == 32'd0) begin
               busy_in = 1'b0; done_in = 1'b1; res_in = acc_ff;
            end
         end
      end
   end

   // Stack count, sticky error and response.
   always_comb begin
      count_in = count_ff; err_in = err_ff; rsp_in = rsp_ff;
      if (cmd.err != pee_pkg::ST_OK && err_ff == pee_pkg::ST_OK) err_in = cmd.err;
      if (cmd.push_digit && count_ff < CW'(STACK_DEPTH)) count_in = count_ff + CW'(1);
      if (cmd.write_res) count_in = count_ff - CW'(1);
      if (cmd.finish) begin
         rsp_in.status = err_in;
         rsp_in.value = (err_in == pee_pkg::ST_OK) ? rhs_ff : '0;
         count_in = '0; err_in = pee_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; err_ff <= pee_pkg::ST_OK; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         count_ff <= count_in; err_ff <= err_in; busy_ff <= busy_in; done_ff <= done_in;
      end
      step_ff <= step_in; op_ff <= op_in; acc_ff <= acc_in; base_ff <= base_in;
      ex_ff <= ex_in; dvs_ff <= dvs_in; res_ff <= res_in; neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.rhs_zero = (rhs_ff == 32'd0);
   assign sts.few = (count_ff < CW'(2));
   assign sts.empty = (count_ff == '0);
   assign sts.full = (count_ff >= CW'(STACK_DEPTH));
   assign rsp_data = rsp_ff;
endmodule

// ===== rtl/core/pee_control.sv =====
`include "postfix_expression_evaluator_macros.svh"
module pee_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pee_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pee_pkg::cmd_type  cmd,
   input  pee_pkg::sts_type  sts
);
   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_START, S_WAIT, S_END, S_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] sym_ff, sym_in;
   logic last_ff, last_in;
   logic is_digit, is_op;
   pee_pkg::op_type op_dec;

   assign is_digit = (sym_ff >= pee_pkg::CHAR_ZERO) && (sym_ff <= pee_pkg::CHAR_NINE);

   // Operator decode.
   always_comb begin
      is_op = 1'b1; op_dec = pee_pkg::OP_ADD;
      case (sym_ff)
         pee_pkg::CHAR_PLUS:  op_dec = pee_pkg::OP_ADD;
         pee_pkg::CHAR_MINUS: op_dec = pee_pkg::OP_SUB;
         pee_pkg::CHAR_TIMES: op_dec = pee_pkg::OP_MUL;
         pee_pkg::CHAR_DIV:   op_dec = pee_pkg::OP_DIV;
         pee_pkg::CHAR_POW:   op_dec = pee_pkg::OP_POW;
         default:             is_op = 1'b0;
      endcase
   end

   // Sequencing of one character.
   always_comb begin
      state_in = state_ff; sym_in = sym_ff; last_in = last_ff;
      cmd = '0; cmd.op = op_dec; cmd.err = pee_pkg::ST_OK;
      cmd.digit = 4'(sym_ff - pee_pkg::CHAR_ZERO);
      case (state_ff)
         S_IDLE: if (req_valid) begin
            sym_in = req_data.symbol; last_in = req_data.last; state_in = S_READ;
         end
         S_READ: begin
            if (is_digit) begin
               cmd.push_digit = 1'b1;
               if (sts.full) cmd.err = pee_pkg::ST_FULL;
               state_in = S_END;
            end else if (is_op) begin
               if (sts.few) begin
                  cmd.err = pee_pkg::ST_UNDER; state_in = S_END;
               end else begin
                  cmd.rd_top = 1'b1; state_in = S_START;
               end
            end else begin
               cmd.err = pee_pkg::ST_UNKNOWN; state_in = S_END;
            end
         end
         S_START: begin
            if (op_dec == pee_pkg::OP_DIV && sts.rhs_zero) begin
               cmd.err = pee_pkg::ST_DIVZERO; state_in = S_END;
            end else begin
               cmd.start = 1'b1; state_in = S_WAIT;
            end
         end
         S_WAIT: if (sts.done) begin
            cmd.write_res = 1'b1; state_in = S_END;
         end
         S_END: begin
            if (!last_ff) state_in = S_IDLE;
            else begin
               cmd.rd_top = 1'b1; state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (sts.empty) cmd.err = pee_pkg::ST_UNDER;
            cmd.finish = 1'b1; state_in = S_OUT;
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      sym_ff <= sym_in; last_ff <= last_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   `PEE_ASSERT_IMPLY(a_ready_idle, clock, reset, req_ready, !rsp_valid, "ready while result pending")
   `PEE_ASSERT_NEXT(a_start_busy, clock, reset, cmd.start && (cmd.op == pee_pkg::OP_DIV), sts.busy, "divider did not start")
   `PEE_ASSERT_NEXT(a_fin_out, clock, reset, cmd.finish, rsp_valid, "finish without result")
endmodule

// ===== rtl/core/postfix_expression_evaluator.sv =====
// Postfix evaluator: one character per transfer; digits push, + - * / ^ pop two operands and
// push the wrapped 32-bit result; an item marked last yields one result (value, status) and
// clears the stack and the sticky status. The block takes one character at a time and accepts
// the next character only after the current one is finished: a division computes one quotient
// bit per cycle in the restoring divider, and a power runs one multiply and one square per
// exponent bit up to its highest set bit on the shared multiplier (a negative exponent needs
// no steps). A last item then reads the top of the stack and holds the result until the
// result side is ready.
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pee_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pee_pkg::rsp_type  rsp_data
);
   pee_pkg::cmd_type cmd;
   pee_pkg::sts_type sts;

   pee_control u_control (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .cmd, .sts
   );

   pee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
      .clock, .reset, .cmd, .sts, .rsp_data
   );
endmodule

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;
   localparam int RANDOM_ITEMS = 1700;
   localparam int CYCLE_LIMIT = 2000000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   pee_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   pee_pkg::rsp_type rsp_data;

   postfix_expression_evaluator #(.STACK_DEPTH(DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Free-running clock, 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Evaluator state as the predictor sees it.
   logic [31:0]      eval_stack [DEPTH];
   int unsigned      eval_count;
   logic [2:0]       eval_error;
   pee_pkg::rsp_type pending_results [$];
   int               mismatches;
   int unsigned      cycles;

   // Directed table: symbol, last, whether the expected result is typed in, and that result.
   typedef struct {
      logic [7:0]  sym;
      logic        fin;
      bit          typed;
      logic [31:0] value;
      logic [2:0]  status;
   } vector_type;

   vector_type vectors [$];

   function automatic void add_vector(logic [7:0] sym, logic fin, bit typed = 1'b0,
                                      logic [31:0] value = 32'd0,
                                      logic [2:0] status = pee_pkg::ST_OK);
      vector_type v;
      v.sym = sym; v.fin = fin; v.typed = typed; v.value = value; v.status = status;
      vectors.push_back(v);
   endfunction

   function automatic void note_error(logic [2:0] code);
      if (eval_error == pee_pkg::ST_OK) eval_error = code;
   endfunction

   function automatic logic [31:0] abs_word(logic [31:0] v);
      return v[31] ? -v : v;
   endfunction

   function automatic logic [31:0] raise_power(logic [31:0] base, logic [31:0] ex);
      logic [31:0] acc;
      acc = 32'd1;
      if (ex[31]) begin
         if (base == 32'd1) return 32'd1;
         if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
         return 32'd0;
      end
      while (ex != 32'd0) begin
         if (ex[0]) acc = acc * base;
         base = base * base;
         ex = ex >> 1;
      end
      return acc;
   endfunction

   // Applies one character to the predicted stack; returns 1 with a result on a last item.
   function automatic bit evaluate_symbol(logic [7:0] sym, logic fin,
                                          output pee_pkg::rsp_type res);
      logic [31:0] lhs, rhs, r, q;
      bit ok;
      res = '0;
      if (sym >= pee_pkg::CHAR_ZERO && sym <= pee_pkg::CHAR_NINE) begin
         if (eval_count >= DEPTH) note_error(pee_pkg::ST_FULL);
         else begin
            eval_stack[eval_count] = 32'(sym - pee_pkg::CHAR_ZERO);
            eval_count++;
         end
      end else if (sym == pee_pkg::CHAR_PLUS || sym == pee_pkg::CHAR_MINUS ||
                   sym == pee_pkg::CHAR_TIMES || sym == pee_pkg::CHAR_DIV ||
                   sym == pee_pkg::CHAR_POW) begin
         if (eval_count < 2) note_error(pee_pkg::ST_UNDER);
         else begin
            rhs = eval_stack[eval_count-1];
            lhs = eval_stack[eval_count-2];
            ok = 1'b1;
            r = 32'd0;
            case (sym)
               pee_pkg::CHAR_PLUS: r = lhs + rhs;
               pee_pkg::CHAR_MINUS: r = lhs - rhs;
               pee_pkg::CHAR_TIMES: r = lhs * rhs;
               pee_pkg::CHAR_DIV: begin
                  if (rhs == 32'd0) begin
                     note_error(pee_pkg::ST_DIVZERO);
                     ok = 1'b0;
                  end else begin
                     q = abs_word(lhs) / abs_word(rhs);
                     r = (lhs[31] ^ rhs[31]) ? -q : q;
                  end
               end
               default: r = raise_power(lhs, rhs);
            endcase
            if (ok) begin
               eval_count--;
               eval_stack[eval_count-1] = r;
            end
         end
      end else begin
         note_error(pee_pkg::ST_UNKNOWN);
      end
      if (!fin) return 1'b0;
      if (eval_count == 0) note_error(pee_pkg::ST_UNDER);
      else res.value = eval_stack[eval_count-1];
      if (eval_error != pee_pkg::ST_OK) res.value = '0;
      res.status = eval_error;
      eval_count = 0;
      eval_error = pee_pkg::ST_OK;
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("error at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
      mismatches++;
   endtask

   // Half the time no gap, otherwise mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Drives one transfer from a falling edge; valid drops only when a gap follows.
   task automatic drive_item(logic [7:0] sym, logic fin);
      int gap;
      req_data <= '{symbol: sym, last: fin};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_item(logic [7:0] sym, logic fin);
      pee_pkg::rsp_type res;
      if (evaluate_symbol(sym, fin, res)) pending_results.push_back(res);
      drive_item(sym, fin);
   endtask

   // Random character: mostly digits and operators, with some unknown bytes.
   function automatic logic [7:0] random_symbol(int digit_weight);
      int p;
      p = $urandom_range(99);
      if (p < digit_weight) return pee_pkg::CHAR_ZERO + 8'($urandom_range(9));
      if (p < 97) begin
         case ($urandom_range(4))
            0: return pee_pkg::CHAR_PLUS;
            1: return pee_pkg::CHAR_MINUS;
            2: return pee_pkg::CHAR_TIMES;
            3: return pee_pkg::CHAR_DIV;
            default: return pee_pkg::CHAR_POW;
         endcase
      end
      return 8'($urandom_range(255));
   endfunction

   // Result side: random back-pressure and in-order comparison.
   always @(posedge clock) begin
      pee_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.value, 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.value !== want.value)
               report_mismatch("value", rsp_data.value, want.value);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
         end
      end
   end

   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(3) == 0) stall = gap_length();
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("postfix_expression_evaluator: mismatch");
         $finish;
      end
   end

   initial begin
      pee_pkg::rsp_type res;
      int n, depth, wait_cycles;
      cycles = 0;
      mismatches = 0;
      eval_count = 0;
      eval_error = pee_pkg::ST_OK;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: edge cases typed where obvious.
      add_vector(pee_pkg::CHAR_ZERO, 1'b1, 1'b1, 32'd0, pee_pkg::ST_OK);
      add_vector(pee_pkg::CHAR_NINE, 1'b1, 1'b1, 32'd9, pee_pkg::ST_OK);
      add_vector(pee_pkg::CHAR_PLUS, 1'b1, 1'b1, 32'd0, pee_pkg::ST_UNDER);
      add_vector(8'hFF, 1'b1, 1'b1, 32'd0, pee_pkg::ST_UNKNOWN);
      add_vector(8'h00, 1'b1, 1'b1, 32'd0, pee_pkg::ST_UNKNOWN);
      add_vector(pee_pkg::CHAR_NINE, 1'b0);
      add_vector(pee_pkg::CHAR_ZERO, 1'b0);
      add_vector(pee_pkg::CHAR_DIV, 1'b1, 1'b1, 32'd0, pee_pkg::ST_DIVZERO);
      add_vector(pee_pkg::CHAR_ZERO, 1'b0);
      add_vector(pee_pkg::CHAR_NINE, 1'b0);
      add_vector(pee_pkg::CHAR_MINUS, 1'b1);
      add_vector(pee_pkg::CHAR_ZERO + 8'd7, 1'b0);
      add_vector(pee_pkg::CHAR_ZERO + 8'd2, 1'b0);
      add_vector(pee_pkg::CHAR_ZERO, 1'b0);
      add_vector(pee_pkg::CHAR_MINUS, 1'b0);
      add_vector(pee_pkg::CHAR_POW, 1'b1);
      add_vector(pee_pkg::CHAR_ZERO, 1'b0);
      add_vector(pee_pkg::CHAR_ZERO, 1'b0);
      add_vector(pee_pkg::CHAR_POW, 1'b1, 1'b1, 32'd1, pee_pkg::ST_OK);
      add_vector(pee_pkg::CHAR_NINE, 1'b0);
      add_vector(pee_pkg::CHAR_NINE, 1'b0);
      add_vector(pee_pkg::CHAR_TIMES, 1'b1, 1'b1, 32'd81, pee_pkg::ST_OK);
      add_vector(pee_pkg::CHAR_ZERO, 1'b0);
      add_vector(pee_pkg::CHAR_ZERO + 8'd7, 1'b0);
      add_vector(pee_pkg::CHAR_MINUS, 1'b0);
      add_vector(pee_pkg::CHAR_ZERO + 8'd2, 1'b0);
      add_vector(pee_pkg::CHAR_DIV, 1'b1, 1'b1, 32'hFFFF_FFFD, pee_pkg::ST_OK);
      foreach (vectors[i]) begin
         if (vectors[i].typed && vectors[i].fin) begin
            // Shadow the table entry so the checker holds the typed result.
            void'(evaluate_symbol(vectors[i].sym, vectors[i].fin, res));
            res.value = vectors[i].value;
            res.status = vectors[i].status;
            pending_results.push_back(res);
            drive_item(vectors[i].sym, vectors[i].fin);
         end else begin
            send_item(vectors[i].sym, vectors[i].fin);
         end
      end

      // Wide values: most negative divided by -1, overflowing powers.
      send_item(pee_pkg::CHAR_ZERO + 8'd2, 1'b0);
      send_item(pee_pkg::CHAR_ZERO + 8'd2, 1'b0);
      send_item(pee_pkg::CHAR_NINE, 1'b0);
      send_item(pee_pkg::CHAR_ZERO + 8'd4, 1'b0);
      send_item(pee_pkg::CHAR_TIMES, 1'b0);
      send_item(pee_pkg::CHAR_ZERO + 8'd5, 1'b0);
      send_item(pee_pkg::CHAR_MINUS, 1'b0);
      send_item(pee_pkg::CHAR_POW, 1'b0);
      send_item(pee_pkg::CHAR_ZERO, 1'b0);
      send_item(pee_pkg::CHAR_ZERO + 8'd1, 1'b0);
      send_item(pee_pkg::CHAR_MINUS, 1'b0);
      send_item(pee_pkg::CHAR_TIMES, 1'b0);
      send_item(pee_pkg::CHAR_ZERO, 1'b0);
      send_item(pee_pkg::CHAR_ZERO + 8'd1, 1'b0);
      send_item(pee_pkg::CHAR_MINUS, 1'b0);
      send_item(pee_pkg::CHAR_DIV, 1'b1);

      // Stack overflow, then negative exponents on bases -1, 0, 1 and 3.
      for (int i = 0; i < DEPTH + 2; i++) send_item(pee_pkg::CHAR_ZERO + 8'(i % 10), 1'b0);
      send_item(pee_pkg::CHAR_PLUS, 1'b1);
      for (int b = 0; b < 4; b++) begin
         send_item(pee_pkg::CHAR_ZERO + 8'(b % 2), 1'b0);
         send_item(pee_pkg::CHAR_ZERO + 8'(b == 3 ? 3 : 1), 1'b0);
         if (b < 2) send_item(pee_pkg::CHAR_MINUS, 1'b0);
         send_item(pee_pkg::CHAR_ZERO, 1'b0);
         send_item(pee_pkg::CHAR_ZERO + 8'(b + 1), 1'b0);
         send_item(pee_pkg::CHAR_MINUS, 1'b0);
         send_item(pee_pkg::CHAR_POW, 1'b1);
      end

      // Random part: mostly well-formed expressions with random content.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if ($urandom_range(9) < 8) begin
            depth = 0;
            send_item(random_symbol(100), 1'b0);
            n++;
            depth = 1;
            repeat ($urandom_range(1, 12)) begin
               if (depth < 2 || ($urandom_range(1) == 0 && depth < DEPTH)) begin
                  send_item(pee_pkg::CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
                  depth++;
               end else begin
                  send_item(random_symbol(0), 1'b0);
                  depth--;
               end
               n++;
            end
            send_item(random_symbol(30), 1'b1);
            n++;
         end else begin
            send_item(8'($urandom_range(255)), 1'($urandom_range(3) == 0));
            n++;
         end
      end
      send_item(pee_pkg::CHAR_ZERO, 1'b1);
      req_valid <= 1'b0;

      // Drain.
      wait_cycles = 0;
      while (pending_results.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("postfix_expression_evaluator: match");
      else
         $display("postfix_expression_evaluator: mismatch");
      $finish;
   end

endmodule
